>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros, clocked on clk_i and gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define UPL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Check a property with a caller-supplied message.
`define UPL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define UPL_ASSERT(lbl, prop)
`define UPL_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> design/upl_pkg.sv
// ---------------------------------------------------------------------------
// Presence light timer package
// Shared types and constants for the ranging light timer.
// ---------------------------------------------------------------------------
package upl_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int THRESH_W  = 9;
  localparam int ON_SEC_W  = 4;
  localparam int TPC_W     = 8;
  localparam int TPS_W     = 24;
  localparam int DIST_OUT_W = 10;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_DIST_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_ON_SECONDS       = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_CM     = 2'd2;
  localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd3;

  localparam logic [THRESH_W-1:0] DIST_THRESHOLD_RST   = 9'd150;
  localparam logic [ON_SEC_W-1:0] ON_SECONDS_RST       = 4'd5;
  localparam logic [TPC_W-1:0]    TICKS_PER_CM_RST     = 8'd58;
  localparam logic [TPS_W-1:0]    TICKS_PER_SECOND_RST = 24'd1000000;

  localparam logic [APB_DATA_W-1:0] DIST_THRESHOLD_MAX = 32'd400;
  localparam logic [APB_DATA_W-1:0] ON_SECONDS_MAX     = 32'd15;
  localparam logic [APB_DATA_W-1:0] TICKS_PER_CM_MAX   = 32'd255;
  localparam logic [APB_DATA_W-1:0] TICKS_PER_SEC_MAX  = 32'd16777215;

  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = 10'd1023;

  // Result queue
  localparam int RES_DEPTH = 3;
  localparam int RES_CNT_W = 2;
  localparam int RES_PTR_W = 2;

  typedef struct packed {
    logic [THRESH_W-1:0] dist_threshold;
    logic [ON_SEC_W-1:0] on_seconds;
    logic [TPC_W-1:0]    ticks_per_cm;
    logic [TPS_W-1:0]    ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic                  trigger;
    logic                  sensing_led;
    logic                  light_on;
    logic                  distance_valid;
    logic [DIST_OUT_W-1:0] distance_cm;
  } res_t;

endpackage

>>> design/upl_if.sv
// ---------------------------------------------------------------------------
// Presence light timer channels
// Valid/ready channels for echo ticks and per-tick results.
// ---------------------------------------------------------------------------
interface upl_tick_if;
  logic valid;
  logic ready;
  logic echo;

  modport source (output valid, output echo, input ready);
  modport sink (input valid, input echo, output ready);
endinterface

interface upl_res_if;
  logic                           valid;
  logic                           ready;
  logic                           trigger;
  logic                           sensing_led;
  logic                           light_on;
  logic                           distance_valid;
  logic [upl_pkg::DIST_OUT_W-1:0] distance_cm;

  modport source (output valid, output trigger, output sensing_led, output light_on,
                  output distance_valid, output distance_cm, input ready);
  modport sink (input valid, input trigger, input sensing_led, input light_on,
                input distance_valid, input distance_cm, output ready);
endinterface

>>> design/upl_cfg_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB register file with range-checked writes.
// ---------------------------------------------------------------------------
module upl_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [upl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [upl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [upl_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output upl_pkg::cfg_t                  cfg_o
);
  import upl_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Drop writes whose value is out of range
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_DIST_THRESHOLD: begin
          if (pwdata != '0 && pwdata <= DIST_THRESHOLD_MAX)
            cfg_d.dist_threshold = pwdata[THRESH_W-1:0];
        end
        REG_ON_SECONDS: begin
          if (pwdata != '0 && pwdata <= ON_SECONDS_MAX)
            cfg_d.on_seconds = pwdata[ON_SEC_W-1:0];
        end
        REG_TICKS_PER_CM: begin
          if (pwdata != '0 && pwdata <= TICKS_PER_CM_MAX)
            cfg_d.ticks_per_cm = pwdata[TPC_W-1:0];
        end
        REG_TICKS_PER_SECOND: begin
          if (pwdata != '0 && pwdata <= TICKS_PER_SEC_MAX)
            cfg_d.ticks_per_second = pwdata[TPS_W-1:0];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_threshold   <= DIST_THRESHOLD_RST;
      cfg_q.on_seconds       <= ON_SECONDS_RST;
      cfg_q.ticks_per_cm     <= TICKS_PER_CM_RST;
      cfg_q.ticks_per_second <= TICKS_PER_SECOND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIST_THRESHOLD:   prdata = APB_DATA_W'(cfg_q.dist_threshold);
      REG_ON_SECONDS:       prdata = APB_DATA_W'(cfg_q.on_seconds);
      REG_TICKS_PER_CM:     prdata = APB_DATA_W'(cfg_q.ticks_per_cm);
      REG_TICKS_PER_SECOND: prdata = APB_DATA_W'(cfg_q.ticks_per_second);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> design/upl_ranger.sv
// ---------------------------------------------------------------------------
// Ranging sequencer
// Input register and per-tick trigger/echo/light state update.
// ---------------------------------------------------------------------------
module upl_ranger #(
  parameter int TRIGGER_TICKS  = 10,
  parameter int DISTANCE_WIDTH = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          echo_i,
  input  upl_pkg::cfg_t cfg_i,
  output logic          busy_o,
  output logic          push_o,
  output upl_pkg::res_t push_data_o
);
  import upl_pkg::*;

  localparam int TcW  = $clog2(TRIGGER_TICKS + 1);
  localparam int ExtW = (DISTANCE_WIDTH > DIST_OUT_W) ? DISTANCE_WIDTH : DIST_OUT_W;
  localparam logic [DISTANCE_WIDTH-1:0] CmMax = {DISTANCE_WIDTH{1'b1}};

  localparam logic [1:0] PH_TRIGGER = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_MEASURE = 2'd2;
  localparam logic [1:0] PH_LIGHT   = 2'd3;

  logic                      tick_vld_q;
  logic                      echo_q;
  logic [1:0]                phase_q, phase_d;
  logic [TcW-1:0]            trig_cnt_q, trig_cnt_d, trig_inc;
  logic [TPC_W-1:0]          sub_q, sub_d, sub_inc;
  logic [DISTANCE_WIDTH-1:0] cm_q, cm_d;
  logic [TPS_W-1:0]          pre_q, pre_d, pre_inc;
  logic [ON_SEC_W-1:0]       sec_q, sec_d;
  logic [DISTANCE_WIDTH-1:0] last_q, last_d;
  logic [ExtW-1:0]           last_ext;
  logic                      trig, sense, light, dvalid;

  assign trig_inc = trig_cnt_q + TcW'(1);
  assign sub_inc  = sub_q + TPC_W'(1);
  assign pre_inc  = pre_q + TPS_W'(1);

  always_comb begin
    phase_d    = phase_q;
    trig_cnt_d = trig_cnt_q;
    sub_d      = sub_q;
    cm_d       = cm_q;
    pre_d      = pre_q;
    sec_d      = sec_q;
    last_d     = last_q;
    trig       = 1'b0;
    sense      = 1'b0;
    light      = 1'b0;
    dvalid     = 1'b0;
    case (phase_q)
      PH_WAIT: begin
        if (echo_q) begin
          sense   = 1'b1;
          cm_d    = DISTANCE_WIDTH'(1);
          sub_d   = '0;
          phase_d = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (echo_q) begin
          sense = 1'b1;
          if (sub_inc >= cfg_i.ticks_per_cm) begin
            sub_d = '0;
            if (cm_q != CmMax) cm_d = cm_q + DISTANCE_WIDTH'(1);
          end else begin
            sub_d = sub_inc;
          end
        end else begin
          dvalid = 1'b1;
          last_d = cm_q;
          if (ExtW'(cm_q) <= ExtW'(cfg_i.dist_threshold)) begin
            phase_d = PH_LIGHT;
            pre_d   = '0;
            sec_d   = '0;
          end else begin
            phase_d    = PH_TRIGGER;
            trig_cnt_d = '0;
          end
        end
      end
      PH_LIGHT: begin
        light = 1'b1;
        if (pre_inc >= cfg_i.ticks_per_second) begin
          pre_d = '0;
          // At-or-beyond test ends the hold cleanly if the setting was lowered
          if (sec_q >= cfg_i.on_seconds) begin
            phase_d    = PH_TRIGGER;
            trig_cnt_d = '0;
          end else begin
            sec_d = sec_q + ON_SEC_W'(1);
          end
        end else begin
          pre_d = pre_inc;
        end
      end
      default: begin
        trig = 1'b1;
        if (trig_inc >= TcW'(TRIGGER_TICKS)) begin
          trig_cnt_d = '0;
          phase_d    = PH_WAIT;
        end else begin
          trig_cnt_d = trig_inc;
        end
      end
    endcase
  end

  assign last_ext = ExtW'(last_d);

  always_comb begin
    push_data_o.trigger        = trig;
    push_data_o.sensing_led    = sense;
    push_data_o.light_on       = light;
    push_data_o.distance_valid = dvalid;
    push_data_o.distance_cm    = (last_ext > ExtW'(DIST_OUT_MAX)) ? DIST_OUT_MAX :
                                 last_ext[DIST_OUT_W-1:0];
  end

  assign push_o = tick_vld_q;
  assign busy_o = tick_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
      echo_q     <= 1'b0;
    end else begin
      tick_vld_q <= accept_i;
      if (accept_i) echo_q <= echo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TRIGGER;
      trig_cnt_q <= '0;
      sub_q      <= '0;
      cm_q       <= '0;
      pre_q      <= '0;
      sec_q      <= '0;
      last_q     <= '0;
    end else if (tick_vld_q) begin
      phase_q    <= phase_d;
      trig_cnt_q <= trig_cnt_d;
      sub_q      <= sub_d;
      cm_q       <= cm_d;
      pre_q      <= pre_d;
      sec_q      <= sec_d;
      last_q     <= last_d;
    end
  end

endmodule

>>> design/upl_res_fifo.sv
// ---------------------------------------------------------------------------
// Result queue
// Small register queue that holds finished results for the output channel.
// ---------------------------------------------------------------------------
module upl_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  upl_pkg::res_t                 push_data_i,
  output logic [upl_pkg::RES_CNT_W-1:0] count_o,
  output logic                          pop_o,
  upl_res_if.source                     res_o
);
  import upl_pkg::*;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic                 pop;
  res_t                 head;

  function automatic logic [RES_PTR_W-1:0] ptr_next(input logic [RES_PTR_W-1:0] p);
    ptr_next = (p == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : p + RES_PTR_W'(1);
  endfunction

  assign head    = mem_q[rd_ptr_q];
  assign pop     = res_o.valid && res_o.ready;
  assign pop_o   = pop;
  assign count_o = cnt_q;

  assign res_o.valid          = (cnt_q != '0);
  assign res_o.trigger        = head.trigger;
  assign res_o.sensing_led    = head.sensing_led;
  assign res_o.light_on       = head.light_on;
  assign res_o.distance_valid = head.distance_valid;
  assign res_o.distance_cm    = head.distance_cm;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop)    rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop)      cnt_q <= cnt_q + RES_CNT_W'(1);
      else if (pop && !push_i) cnt_q <= cnt_q - RES_CNT_W'(1);
    end
  end

endmodule

>>> design/ultrasonic_presence_light_timer.sv
// ---------------------------------------------------------------------------
// Ultrasonic presence light timer
// Echo-pulse ranging sequencer that drives a presence light.
// ---------------------------------------------------------------------------
// Every transaction on tick_i is one microsecond tick carrying the sampled
// echo pin, and every tick yields exactly one result transaction on
// result_o. The block takes one tick per clock cycle while tick_i.ready is
// high; a result passes through the input register, then the result
// queue. The three-entry result queue absorbs one more tick once the
// consumer holds off; after that the input stalls until a result leaves.
// Each measurement pulses trigger for
// TRIGGER_TICKS ticks, waits for the echo to rise, counts centimetres while
// it stays high (one on the first high tick, then one every ticks_per_cm
// ticks, saturating at the DISTANCE_WIDTH limit), and reports the distance,
// capped at 1023, on the falling edge. At or below dist_threshold the light
// stays on for on_seconds+1 seconds of ticks_per_second ticks before the next
// measurement. There is no echo timeout. Configuration writes with values
// out of range are dropped; write only while no tick is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_presence_light_timer #(
  parameter int TRIGGER_TICKS  = 10,
  parameter int DISTANCE_WIDTH = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [upl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [upl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [upl_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  upl_tick_if.sink                       tick_i,
  upl_res_if.source                      result_o
);
  import upl_pkg::*;

  cfg_t                 cfg;
  logic                 accept;
  logic                 busy;
  logic                 push;
  logic                 pop;
  res_t                 push_data;
  logic [RES_CNT_W-1:0] q_count;
  logic [RES_CNT_W:0]   committed;

  // Count queued results plus the tick in the input register; hold off once
  // every queue slot is spoken for, independent of result_o.ready.
  assign committed    = (RES_CNT_W + 1)'(q_count) + (RES_CNT_W + 1)'(busy);
  assign tick_i.ready = (committed < (RES_CNT_W + 1)'(RES_DEPTH));
  assign accept       = tick_i.valid && tick_i.ready;

  upl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  upl_ranger #(
    .TRIGGER_TICKS  (TRIGGER_TICKS),
    .DISTANCE_WIDTH (DISTANCE_WIDTH)
  ) u_ranger (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .echo_i      (tick_i.echo),
    .cfg_i       (cfg),
    .busy_o      (busy),
    .push_o      (push),
    .push_data_o (push_data)
  );

  upl_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .count_o     (q_count),
    .pop_o       (pop),
    .res_o       (result_o)
  );

  // Queue must never be full when a result lands, unless a result leaves at once
  `UPL_ASSERT(a_no_overflow, push |-> (q_count != RES_CNT_W'(RES_DEPTH)) || pop)
  // Slots spoken for never exceed the queue depth
  `UPL_ASSERT_MSG(a_commit_bound, committed <= (RES_CNT_W + 1)'(RES_DEPTH), "queue overbooked")
  // At most one of trigger, sensing and light per tick
  `UPL_ASSERT(a_phase_excl, push |-> $onehot0({push_data.trigger, push_data.sensing_led,
    push_data.light_on}))
  // A completed measurement is never reported as an echo-high tick
  `UPL_ASSERT(a_done_not_sensing, push && push_data.distance_valid |-> !push_data.sensing_led)

endmodule
